// File: rtl/rdvc_pkg.sv
// Package for the row distinct-value counter: beat structs and IEEE-754 constants.
// No dependencies.
package rdvc_pkg;

   localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
   localparam logic [31:0] NA_LOW_WORD  = 32'd1954;
   localparam int unsigned COUNT_W      = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   typedef struct packed {
      logic [63:0] sample_bits;
      logic        row_end;
      logic        empty_row;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] distinct_count;
      logic               table_overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

// File: rtl/rdvc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rdvc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/row_distinct_value_counter.sv
// Top level of the row distinct-value counter.
// Depends on rdvc_pkg and rdvc_ram.
//
// Counts distinct doubles per row. Each beat carrying an ordinary value is
// checked against the row's table by reading one stored entry per cycle through
// the single table RAM read port. The scan stops at the first matching entry or
// after the last of the entries stored so far in the row (up to MAX_DISTINCT);
// a value not found is then inserted, or flags overflow if the table is full.
// The first value of a row skips the scan; NaN, NA and empty-row beats need no
// table access. A row result waits in an output register and the next beat is
// accepted meanwhile unless it closes another row, in which case it waits until
// the result has been read. No clearing pass is needed after reset.
module row_distinct_value_counter #(
   parameter int MAX_DISTINCT = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rdvc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rdvc_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
   localparam int FW = $clog2(MAX_DISTINCT + 1);
   localparam int SW = (FW > rdvc_pkg::COUNT_W) ? FW + 1 : rdvc_pkg::COUNT_W + 1;
   localparam logic [FW-1:0] FILL_MAX = FW'(MAX_DISTINCT);

   rdvc_pkg::state_type state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          na_ff, na_in, nan_ff, nan_in, ovf_ff, ovf_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [63:0]   val_ff, val_in;
   logic          last_ff, last_in;
   logic          hit_ff, hit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rdvc_pkg::rsp_type rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   rd_data;

   logic          accept, is_nan, is_na, closes;
   logic [63:0]   norm;
   rdvc_pkg::rsp_type result;

   rdvc_ram #(.WIDTH(64), .DEPTH(MAX_DISTINCT)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign is_nan = (req_data.sample_bits[62:52] == rdvc_pkg::EXP_ALL_ONES)
                   && (req_data.sample_bits[51:0] != '0);
   assign is_na  = req_data.sample_bits[31:0] == rdvc_pkg::NA_LOW_WORD;
   assign norm   = (req_data.sample_bits[62:0] == '0) ? '0 : req_data.sample_bits;
   assign closes = req_data.empty_row || req_data.row_end;

   // hold a closing beat while the previous result is still unread
   assign req_ready = (state_ff == rdvc_pkg::ST_IDLE) && !(closes && rsp_valid_ff);
   assign accept    = req_valid && req_ready;

   // result from current flags (passed in via arguments)
   function automatic rdvc_pkg::rsp_type mk(input logic [FW-1:0] f, input logic a,
                                            input logic b, input logic o);
      logic [SW-1:0] s;
      rdvc_pkg::rsp_type r;
      s = SW'(f) + SW'(a) + SW'(b);
      r.distinct_count = (s > SW'(rdvc_pkg::COUNT_MAX)) ? rdvc_pkg::COUNT_MAX
                                                        : s[rdvc_pkg::COUNT_W-1:0];
      r.table_overflow = o;
      return r;
   endfunction

   assign result = mk(fill_ff, na_ff, nan_ff, ovf_ff);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      na_in        = na_ff;
      nan_in       = nan_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[AW-1:0];
      rd_addr      = '0;
      case (state_ff)
         rdvc_pkg::ST_IDLE: begin
            if (accept) begin
               last_in = req_data.row_end;
               val_in  = norm;
               idx_in  = '0;
               hit_in  = 1'b0;
               if (req_data.empty_row) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = result;
                  fill_in = '0; na_in = 1'b0; nan_in = 1'b0; ovf_in = 1'b0;
               end else if (is_nan) begin
                  if (req_data.row_end) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = mk(fill_ff, na_ff | is_na, nan_ff | !is_na, ovf_ff);
                     fill_in = '0; na_in = 1'b0; nan_in = 1'b0; ovf_in = 1'b0;
                  end else if (is_na) begin
                     na_in = 1'b1;
                  end else begin
                     nan_in = 1'b1;
                  end
               end else if (fill_ff == '0) begin
                  state_in = rdvc_pkg::ST_DONE;
               end else begin
                  // issue first table read
                  rd_addr  = '0;
                  state_in = rdvc_pkg::ST_SCAN;
               end
            end
         end
         rdvc_pkg::ST_SCAN: begin
            // rd_data holds entry idx_ff
            if (rd_data == val_ff) begin
               hit_in   = 1'b1;
               state_in = rdvc_pkg::ST_DONE;
            end else if (idx_ff + FW'(1) == fill_ff) begin
               state_in = rdvc_pkg::ST_DONE;
            end else begin
               idx_in   = idx_ff + FW'(1);
               rd_addr  = idx_in[AW-1:0];
            end
         end
         rdvc_pkg::ST_DONE: begin
            // insert a value that was not found, or flag a full table; on a row end, emit the result
            state_in = rdvc_pkg::ST_IDLE;
            if (!hit_ff) begin
               if (fill_ff == FILL_MAX) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + FW'(1);
               end
            end
            if (last_ff) begin
               if (!rsp_valid_in) begin
                  rsp_valid_in = 1'b1;
                  rsp_in  = mk(fill_in, na_ff, nan_ff, ovf_in);
                  fill_in = '0; na_in = 1'b0; nan_in = 1'b0; ovf_in = 1'b0;
               end else begin
                  // output still full: retry, insertion already done
                  state_in = rdvc_pkg::ST_DONE;
                  hit_in   = 1'b1;
               end
            end
         end
         default: state_in = rdvc_pkg::ST_IDLE;
      endcase
      if (state_ff == rdvc_pkg::ST_IDLE && accept && state_in == rdvc_pkg::ST_SCAN) begin
         rd_addr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdvc_pkg::ST_IDLE;
         fill_ff      <= '0;
         na_ff        <= 1'b0;
         nan_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         na_ff        <= na_in;
         nan_ff       <= nan_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      last_ff <= last_in;
      hit_ff  <= hit_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
